// ===== src/pdm_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the pairwise distance block
package pdm_pkg;

    localparam int MAX_POINTS = 64;
    localparam int MAX_DIMS   = 8;
    localparam int PT_W       = $clog2(MAX_POINTS);
    localparam int DIM_W      = $clog2(MAX_DIMS);
    localparam int ADDR_W     = PT_W + DIM_W;
    localparam int DEPTH      = MAX_POINTS * MAX_DIMS;
    localparam int COORD_W    = 32;
    localparam int ACC_W      = 2 * COORD_W + DIM_W;
    localparam int ROOT_W     = 35;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 3;
    localparam int NPTS_W     = 7;
    localparam int NDIM_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MAC  = 4'b0010,
        ST_SQRT = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

endpackage

// ===== src/pairwise_distance_matrix.sv =====
`timescale 1ns / 1ps
// pairwise euclidean distance matrix over a streamed point set
//
// Coordinates (signed Q16.16) arrive one per transaction, dims_in_use per
// point and point_count points per set, and are kept in a 512-word store.
// A coordinate that does not finish a point leaves s_ready high. When the
// last coordinate of point j arrives, the block emits one result transaction
// per earlier point i = 0..j-1 (upper triangle only) with the floor square
// root of the summed squared differences as unsigned Q19.16. Each pair runs
// on one shared datapath: a pipelined read / subtract / 32x32 square /
// accumulate pass over the dims_in_use coordinates, then a bit-serial square
// root, then the result register, which holds each pair until m_ready. s_ready
// is low from the last coordinate of a point until its last pair is taken.
// Writing either configuration register (only while idle) restarts the set
// at point 0; stored coordinates are kept. Out-of-range settings are clamped.
module pairwise_distance_matrix (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [pdm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pdm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // coordinate stream
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [pdm_pkg::COORD_W-1:0]  s_coordinate,
    // distance results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pdm_pkg::PT_W-1:0]            m_first_point,
    output logic [pdm_pkg::PT_W-1:0]            m_second_point,
    output logic [pdm_pkg::ROOT_W-1:0]          m_distance,
    output logic                                m_last_of_point,
    output logic                                m_set_done
);
    localparam int PT_W   = pdm_pkg::PT_W;
    localparam int DIM_W  = pdm_pkg::DIM_W;
    localparam int CW     = pdm_pkg::COORD_W;
    localparam int ACC_W  = pdm_pkg::ACC_W;
    localparam int ROOT_W = pdm_pkg::ROOT_W;
    localparam int RAD_W  = pdm_pkg::RAD_W;
    localparam int REM_W  = pdm_pkg::REM_W;
    localparam int NPW    = pdm_pkg::NPTS_W;
    localparam int NDW    = pdm_pkg::NDIM_W;

    pdm_pkg::state_t state_reg, state_next;

    // configuration registers and clamped copies
    logic [NPW-1:0] npts_reg;
    logic [NDW-1:0] ndim_reg;
    logic [NPW-1:0] np_eff;
    logic [NDW-1:0] nd_eff;

    always_comb begin
        np_eff = npts_reg;
        if (npts_reg < NPW'(2))
            np_eff = NPW'(2);
        else if (npts_reg > NPW'(pdm_pkg::MAX_POINTS))
            np_eff = NPW'(pdm_pkg::MAX_POINTS);
        nd_eff = ndim_reg;
        if (ndim_reg == '0)
            nd_eff = NDW'(1);
        else if (ndim_reg > NDW'(pdm_pkg::MAX_DIMS))
            nd_eff = NDW'(pdm_pkg::MAX_DIMS);
    end

    // stream position
    logic [PT_W-1:0]  pt_reg;
    logic [DIM_W-1:0] crd_reg;
    logic             s_fire;
    logic             pt_done;

    assign s_ready = (state_reg == pdm_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign pt_done = ({1'b0, crd_reg} + 1'b1) == nd_eff;

    // copy of the point being received, indexed by coordinate
    logic [CW-1:0] cur_reg [pdm_pkg::MAX_DIMS];

    // pair sequencing
    logic [PT_W-1:0]  pj_reg;     // point just completed
    logic [PT_W-1:0]  pi_reg;     // earlier point under work
    logic             set_end_reg;
    logic [NDW-1:0]   iss_reg;    // coordinates issued to the store read
    logic             v1_reg, v2_reg, v3_reg;
    logic [DIM_W-1:0] k1_reg;
    logic [CW-1:0]    mag_reg;
    logic [2*CW-1:0]  sq_reg;
    logic [ACC_W-1:0] acc_reg;

    // square root
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [5:0]        sq_cnt_reg;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign take   = rem_sh >= trial;

    // coordinate store
    logic              rd_en;
    logic [CW-1:0]     rd_data;
    logic              issue;

    assign issue = (state_reg == pdm_pkg::ST_MAC) && (iss_reg < nd_eff);
    assign rd_en = issue;

    pdm_ram #(
        .WIDTH (CW),
        .DEPTH (pdm_pkg::DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (s_fire),
        .waddr ({pt_reg, crd_reg}),
        .wdata (s_coordinate),
        .re    (rd_en),
        .raddr ({pi_reg, iss_reg[DIM_W-1:0]}),
        .rdata (rd_data)
    );

    // subtract in 33 bits, keep the magnitude
    logic [CW:0] diff;
    logic [CW:0] diff_abs;
    assign diff     = {rd_data[CW-1], rd_data} - {cur_reg[k1_reg][CW-1], cur_reg[k1_reg]};
    assign diff_abs = diff[CW] ? (~diff + 1'b1) : diff;

    logic mac_done;
    assign mac_done = (iss_reg == nd_eff) && !v1_reg && !v2_reg && !v3_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pdm_pkg::ST_IDLE: begin
                if (s_fire && pt_done && pt_reg != '0)
                    state_next = pdm_pkg::ST_MAC;
            end
            pdm_pkg::ST_MAC: begin
                if (mac_done)
                    state_next = pdm_pkg::ST_SQRT;
            end
            pdm_pkg::ST_SQRT: begin
                if (sq_cnt_reg == 6'(ROOT_W - 1))
                    state_next = pdm_pkg::ST_OUT;
            end
            pdm_pkg::ST_OUT: begin
                if (m_ready)
                    state_next = (pi_reg + 1'b1 == pj_reg) ? pdm_pkg::ST_IDLE
                                                           : pdm_pkg::ST_MAC;
            end
            default: state_next = pdm_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pdm_pkg::ST_IDLE;
            npts_reg  <= NPW'(64);
            ndim_reg  <= NDW'(3);
            pt_reg    <= '0;
            crd_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            iss_reg   <= '0;
        end else begin
            state_reg <= state_next;
            // config write restarts the set
            if (cfg_we && (cfg_index == pdm_pkg::REG_POINT_COUNT ||
                           cfg_index == pdm_pkg::REG_DIMS_IN_USE)) begin
                if (cfg_index == pdm_pkg::REG_POINT_COUNT)
                    npts_reg <= cfg_wdata;
                else
                    ndim_reg <= cfg_wdata[NDW-1:0];
                pt_reg  <= '0;
                crd_reg <= '0;
            end else if (s_fire) begin
                if (pt_done) begin
                    crd_reg <= '0;
                    if ({1'b0, pt_reg} + 1'b1 >= np_eff)
                        pt_reg <= '0;
                    else
                        pt_reg <= pt_reg + 1'b1;
                end else begin
                    crd_reg <= crd_reg + 1'b1;
                end
            end
            // read / subtract / square pipeline valids
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (issue)
                iss_reg <= iss_reg + 1'b1;
            else if (state_reg != pdm_pkg::ST_MAC)
                iss_reg <= '0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cur_reg[crd_reg] <= s_coordinate;
            if (pt_done) begin
                pj_reg      <= pt_reg;
                set_end_reg <= ({1'b0, pt_reg} + 1'b1) == np_eff;
                pi_reg      <= '0;
                acc_reg     <= '0;
            end
        end
        k1_reg  <= iss_reg[DIM_W-1:0];
        mag_reg <= diff_abs[CW-1:0];
        sq_reg  <= mag_reg * mag_reg;
        if (v3_reg)
            acc_reg <= acc_reg + ACC_W'(sq_reg);
        if (state_reg == pdm_pkg::ST_MAC && mac_done) begin
            rad_reg    <= RAD_W'(acc_reg);
            rem_reg    <= '0;
            root_reg   <= '0;
            sq_cnt_reg <= '0;
        end
        if (state_reg == pdm_pkg::ST_SQRT) begin
            rad_reg    <= rad_reg << 2;
            rem_reg    <= take ? (rem_sh - trial) : rem_sh;
            root_reg   <= {root_reg[ROOT_W-2:0], take};
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
        end
        if (state_reg == pdm_pkg::ST_OUT && m_ready) begin
            pi_reg  <= pi_reg + 1'b1;
            acc_reg <= '0;
        end
    end

    // result transaction
    assign m_valid         = (state_reg == pdm_pkg::ST_OUT);
    assign m_first_point   = pi_reg;
    assign m_second_point  = pj_reg;
    assign m_distance      = root_reg;
    assign m_last_of_point = (pi_reg + 1'b1) == pj_reg;
    assign m_set_done      = m_last_of_point && set_end_reg;

endmodule

// ===== src/pdm_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module pdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== tb/tb_pairwise_distance_matrix.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the pairwise distance matrix block
module tb_pairwise_distance_matrix;

    // one expected upper-triangle entry
    typedef struct {
        logic [pdm_pkg::PT_W-1:0]   first_point;
        logic [pdm_pkg::PT_W-1:0]   second_point;
        logic [pdm_pkg::ROOT_W-1:0] distance;
        logic                       last_of_point;
        logic                       set_done;
    } pair_result_t;

    // mirrors the block: coordinate store, point / coordinate position, settings
    class distance_scoreboard;
        logic [pdm_pkg::COORD_W-1:0] coord_store [pdm_pkg::DEPTH];
        int unsigned                 point_idx;
        int unsigned                 coord_idx;
        logic [pdm_pkg::NPTS_W-1:0]  point_count_reg;
        logic [pdm_pkg::NDIM_W-1:0]  dims_reg;
        pair_result_t                expected_pairs [$];
        int                          mismatches;

        function new();
            foreach (coord_store[n]) coord_store[n] = '0;
            point_idx = 0;
            coord_idx = 0;
            point_count_reg = 7'd64;
            dims_reg = 4'd3;
            mismatches = 0;
        endfunction

        function void write_register(logic [pdm_pkg::CFG_IDX_W-1:0] idx,
                                     logic [pdm_pkg::CFG_DATA_W-1:0] val);
            if (idx == pdm_pkg::REG_POINT_COUNT) begin
                point_count_reg = val;
            end else if (idx == pdm_pkg::REG_DIMS_IN_USE) begin
                dims_reg = val[pdm_pkg::NDIM_W-1:0];
            end else begin
                return;
            end
            point_idx = 0;
            coord_idx = 0;
        endfunction

        function int unsigned points_per_set();
            if (point_count_reg < 2) return 2;
            if (point_count_reg > pdm_pkg::MAX_POINTS) return pdm_pkg::MAX_POINTS;
            return point_count_reg;
        endfunction

        function int unsigned dims_per_point();
            if (dims_reg < 1) return 1;
            if (dims_reg > pdm_pkg::MAX_DIMS) return pdm_pkg::MAX_DIMS;
            return dims_reg;
        endfunction

        // floor square root, bit by bit from the top
        function logic [pdm_pkg::ROOT_W-1:0] floor_root(logic [67:0] s);
            logic [35:0] r;
            logic [35:0] c;
            logic [71:0] sq;
            r = '0;
            for (int b = 35; b >= 0; b--) begin
                c = r | (36'd1 << b);
                sq = {36'd0, c} * {36'd0, c};
                if (sq <= {4'd0, s}) r = c;
            end
            return r[pdm_pkg::ROOT_W-1:0];
        endfunction

        function void note_coordinate(logic [pdm_pkg::COORD_W-1:0] coord);
            int unsigned np;
            int unsigned nd;
            logic [67:0] acc;
            longint      diff;
            logic [63:0] mag;
            pair_result_t pr;
            np = points_per_set();
            nd = dims_per_point();
            coord_store[point_idx * pdm_pkg::MAX_DIMS + coord_idx] = coord;
            coord_idx++;
            if (coord_idx < nd) return;
            coord_idx = 0;
            for (int unsigned i = 0; i < point_idx; i++) begin
                acc = '0;
                for (int unsigned k = 0; k < nd; k++) begin
                    diff = longint'($signed(coord_store[i * pdm_pkg::MAX_DIMS + k]))
                         - longint'($signed(coord_store[point_idx * pdm_pkg::MAX_DIMS + k]));
                    mag = (diff < 0) ? -diff : diff;
                    acc += {4'd0, mag * mag};
                end
                pr.first_point   = i[pdm_pkg::PT_W-1:0];
                pr.second_point  = point_idx[pdm_pkg::PT_W-1:0];
                pr.distance      = floor_root(acc);
                pr.last_of_point = (i + 1 == point_idx);
                pr.set_done      = (i + 1 == point_idx) && (point_idx + 1 == np);
                expected_pairs.push_back(pr);
            end
            point_idx++;
            if (point_idx >= np) point_idx = 0;
        endfunction

        function void check_pair(pair_result_t got);
            pair_result_t want;
            if (expected_pairs.size() == 0) begin
                $error("unexpected result transaction: first_point %0d second_point %0d",
                       got.first_point, got.second_point);
                mismatches++;
                return;
            end
            want = expected_pairs.pop_front();
            if (got.first_point !== want.first_point) begin
                $error("first_point: expected %0d, actual %0d", want.first_point, got.first_point);
                mismatches++;
            end
            if (got.second_point !== want.second_point) begin
                $error("second_point: expected %0d, actual %0d",
                       want.second_point, got.second_point);
                mismatches++;
            end
            if (got.distance !== want.distance) begin
                $error("distance: expected %0h, actual %0h", want.distance, got.distance);
                mismatches++;
            end
            if (got.last_of_point !== want.last_of_point) begin
                $error("last_of_point: expected %0b, actual %0b",
                       want.last_of_point, got.last_of_point);
                mismatches++;
            end
            if (got.set_done !== want.set_done) begin
                $error("set_done: expected %0b, actual %0b", want.set_done, got.set_done);
                mismatches++;
            end
        endfunction
    endclass

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [pdm_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [pdm_pkg::CFG_DATA_W-1:0]       cfg_wdata = '0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic signed [pdm_pkg::COORD_W-1:0]   s_coordinate = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic [pdm_pkg::PT_W-1:0]             m_first_point;
    logic [pdm_pkg::PT_W-1:0]             m_second_point;
    logic [pdm_pkg::ROOT_W-1:0]           m_distance;
    logic                                 m_last_of_point;
    logic                                 m_set_done;

    distance_scoreboard sb = new();
    bit quiet = 1'b0;          // no idling in the closing phase
    int items_sent = 0;
    int ready_hold = 0;

    pairwise_distance_matrix DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_coordinate    (s_coordinate),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_first_point   (m_first_point),
        .m_second_point  (m_second_point),
        .m_distance      (m_distance),
        .m_last_of_point (m_last_of_point),
        .m_set_done      (m_set_done)
    );

    always #1 aclk = ~aclk;

    // receiver: stalls come in random bursts, none once quiet is set
    always @(posedge aclk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            ready_hold <= $urandom_range(0, 17);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result monitor: values seen here are the ones from before the edge
    always @(posedge aclk) begin
        pair_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.first_point   = m_first_point;
            got.second_point  = m_second_point;
            got.distance      = m_distance;
            got.last_of_point = m_last_of_point;
            got.set_done      = m_set_done;
            sb.check_pair(got);
        end
    end

    // coordinate mix: full random, small whole Q16.16 values, extremes, small values near zero
    function automatic logic [pdm_pkg::COORD_W-1:0] pick_coordinate();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return $signed($urandom_range(0, 16) - 8) <<< 16;
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            default: return $signed($urandom_range(0, 2000) - 1000);
        endcase
    endfunction

    // one coordinate transaction; valid stays high into the next call
    task automatic send_coordinate(logic [pdm_pkg::COORD_W-1:0] coord);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_coordinate <= coord;
        do @(posedge aclk); while (!s_ready);
        sb.note_coordinate(coord);
        items_sent++;
    endtask

    // stop sending and let every expected result come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_pairs.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    task automatic write_register(logic [pdm_pkg::CFG_IDX_W-1:0] idx,
                                  logic [pdm_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_register(idx, val);
        @(posedge aclk);
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++) send_coordinate(pick_coordinate());
    endtask

    initial begin
        int np;
        int nd;
        int cnt;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, 3 coordinates per point: extremes of the coordinate, zero and small values
        repeat (3) send_coordinate(32'h8000_0000);
        repeat (3) send_coordinate(32'h7fff_ffff);
        repeat (3) send_coordinate(32'h0000_0000);
        send_coordinate(32'hffff_ffff);
        send_coordinate(32'h0001_0000);
        send_coordinate(32'hffff_0000);
        drain();

        // point count below range acts as 2, zero dims act as 1: sets wrap often
        write_register(pdm_pkg::REG_POINT_COUNT, 7'd1);
        write_register(pdm_pkg::REG_DIMS_IN_USE, 7'd0);
        send_coordinate(32'h7fff_ffff);
        send_coordinate(32'h8000_0000);
        send_coordinate(32'h0000_0001);
        drain();
        // unknown indexes are ignored and leave the set position alone
        write_register(2'd2, 7'h7f);
        write_register(2'd3, 7'h55);
        send_coordinate(32'h1234_5678);
        send_coordinate(32'hedcb_a988);
        drain();

        // both above range: 64 points of 8 dims; worst-case sums with extremes
        write_register(pdm_pkg::REG_POINT_COUNT, 7'd127);
        write_register(pdm_pkg::REG_DIMS_IN_USE, 7'd15);
        repeat (8) send_coordinate(32'h8000_0000);
        repeat (8) send_coordinate(32'h7fff_ffff);
        send_random(12);
        // sender holds off until every result is back
        drain();
        send_random(20);
        drain();

        // one full set of 64 one-dimensional points, including the set wrap
        write_register(pdm_pkg::REG_POINT_COUNT, 7'd64);
        write_register(pdm_pkg::REG_DIMS_IN_USE, 7'd1);
        send_random(64);
        drain();

        // random small settings, occasionally out of range or ending mid-point
        while (items_sent < 160) begin
            np = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 8);
            nd = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            write_register(pdm_pkg::REG_POINT_COUNT, np[pdm_pkg::CFG_DATA_W-1:0]);
            write_register(pdm_pkg::REG_DIMS_IN_USE, nd[pdm_pkg::CFG_DATA_W-1:0]);
            cnt = $urandom_range(2, 14) * ((nd < 1) ? 1 : (nd > 8) ? 8 : nd)
                + $urandom_range(0, 2);
            // keep the total item count near its target
            if (items_sent + cnt > 165) cnt = 165 - items_sent;
            send_random(cnt);
            drain();
        end

        // closing phase with no idling on either side
        quiet = 1'b1;
        write_register(pdm_pkg::REG_POINT_COUNT, 7'd5);
        write_register(pdm_pkg::REG_DIMS_IN_USE, 7'd2);
        send_random(20);
        drain();

        // time for any stray result to show up
        repeat (100) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
